FILE: src/mpp_pkg.sv
package mpp_pkg;

  // Packet sections; the same codes serve as parser phase and byte kind
  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LENGTH  = 3'd1;
  localparam logic [2:0] PH_TLEN    = 3'd2;
  localparam logic [2:0] PH_TOPIC   = 3'd3;
  localparam logic [2:0] PH_IDENT   = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_IGNORE  = 3'd6;

  // Status codes reported on the last byte
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_PUB    = 3'd1;
  localparam logic [2:0] ST_QOS_BOTH   = 3'd2;
  localparam logic [2:0] ST_BAD_LEN    = 3'd3;
  localparam logic [2:0] ST_LEN_OVER   = 3'd4;
  localparam logic [2:0] ST_TOPIC_SHRT = 3'd5;
  localparam logic [2:0] ST_ID_SHRT    = 3'd6;

  localparam logic [3:0] PUBLISH_TYPE = 4'd3;
  localparam logic [1:0] FIELD_BYTES  = 2'd2;

  localparam logic [27:0] MAX28 = 28'hFFF_FFFF;
  localparam logic [28:0] MAX29 = 29'h1FFF_FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } mpp_in_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  out_byte;
    logic        done_res;
    logic [2:0]  status;
    logic        dup_flag;
    logic [1:0]  qos_level;
    logic        retain_flag;
    logic [15:0] topic_length;
    logic [15:0] packet_ident;
    logic [27:0] payload_length;
  } mpp_out_t;

endpackage

FILE: src/mpp_parse_core.sv
module mpp_parse_core
  import mpp_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  mpp_in_t  beat_in,
  output mpp_out_t result
);

  localparam logic [2:0] LEN_MAX = 3'(MAX_LENGTH_BYTES);

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [27:0] accum_r, accum_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [28:0] after_r, after_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] tleft_r, tleft_nxt;
  logic [15:0] ident_r, ident_nxt;
  logic [27:0] pcount_r, pcount_nxt;
  logic [2:0]  err_r, err_nxt;

  logic [7:0]  b;
  logic [27:0] accum_part;
  logic [2:0]  after_topic;
  logic [2:0]  st;
  logic [1:0]  qos;
  logic [15:0] tleft_dec;

  assign b = beat_in.in_byte;
  assign after_topic = (flags_r[2:1] != 2'b00) ? PH_IDENT : PH_PAYLOAD;

  // varint group placed at its 7-bit position
  always_comb begin
    case (seen_r[1:0])
      2'd0: accum_part = {21'd0, b[6:0]};
      2'd1: accum_part = {14'd0, b[6:0], 7'd0};
      2'd2: accum_part = {7'd0, b[6:0], 14'd0};
      default: accum_part = {b[6:0], 21'd0};
    endcase
  end

  // phase machine: next state for one byte
  always_comb begin
    phase_nxt  = phase_r;
    flags_nxt  = flags_r;
    accum_nxt  = accum_r;
    seen_nxt   = seen_r;
    after_nxt  = after_r;
    tlen_nxt   = tlen_r;
    tleft_nxt  = tleft_r;
    ident_nxt  = ident_r;
    pcount_nxt = pcount_r;
    err_nxt    = err_r;
    tleft_dec  = tleft_r;
    if (phase_r inside {PH_TLEN, PH_TOPIC, PH_IDENT, PH_PAYLOAD}) begin
      if (after_r != MAX29) after_nxt = after_r + 29'd1;
    end
    case (phase_r)
      PH_HEADER: begin
        if (b[7:4] != PUBLISH_TYPE) begin
          flags_nxt = 4'd0;
          err_nxt   = ST_NOT_PUB;
          phase_nxt = PH_IGNORE;
        end else begin
          flags_nxt = b[3:0];
          if (b[2:1] == 2'b11) begin
            err_nxt   = ST_QOS_BOTH;
            phase_nxt = PH_IGNORE;
          end else begin
            phase_nxt = PH_LENGTH;
          end
        end
        accum_nxt = 28'd0;
        seen_nxt  = 3'd0;
      end
      PH_LENGTH: begin
        accum_nxt = accum_r | accum_part;
        seen_nxt  = seen_r + 3'd1;
        if (!b[7]) begin
          seen_nxt  = 3'd0;
          phase_nxt = PH_TLEN;
        end else if (seen_nxt >= LEN_MAX) begin
          err_nxt   = ST_BAD_LEN;
          phase_nxt = PH_IGNORE;
        end
      end
      PH_TLEN: begin
        tlen_nxt = {tlen_r[7:0], b};
        seen_nxt = seen_r + 3'd1;
        if (seen_nxt >= 3'(FIELD_BYTES)) begin
          seen_nxt  = 3'd0;
          tleft_nxt = tlen_nxt;
          phase_nxt = (tlen_nxt != 16'd0) ? PH_TOPIC : after_topic;
        end
      end
      PH_TOPIC: begin
        if (tleft_r != 16'd0) tleft_dec = tleft_r - 16'd1;
        tleft_nxt = tleft_dec;
        if (tleft_dec == 16'd0) phase_nxt = after_topic;
      end
      PH_IDENT: begin
        ident_nxt = {ident_r[7:0], b};
        seen_nxt  = seen_r + 3'd1;
        if (seen_nxt >= 3'(FIELD_BYTES)) begin
          seen_nxt  = 3'd0;
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (pcount_r != MAX28) pcount_nxt = pcount_r + 28'd1;
      end
      default: phase_nxt = PH_IGNORE;
    endcase
  end

  // status from the updated state, by precedence
  always_comb begin
    if (err_nxt != ST_OK) st = err_nxt;
    else if ((phase_nxt == PH_HEADER) || (phase_nxt == PH_LENGTH)) st = ST_BAD_LEN;
    else if ({1'b0, accum_nxt} > after_nxt) st = ST_LEN_OVER;
    else if ((phase_nxt == PH_TLEN) || (phase_nxt == PH_TOPIC)) st = ST_TOPIC_SHRT;
    else if (phase_nxt == PH_IDENT) st = ST_ID_SHRT;
    else st = ST_OK;
  end

  assign qos = flags_nxt[2] ? 2'd2 : (flags_nxt[1] ? 2'd1 : 2'd0);

  // result beat
  always_comb begin
    result = '0;
    result.byte_kind = phase_r;
    result.out_byte  = b;
    result.done_res  = beat_in.last_byte;
    if (beat_in.last_byte) begin
      result.status = st;
      if (st != ST_NOT_PUB) begin
        result.dup_flag    = flags_nxt[3];
        result.retain_flag = flags_nxt[0];
        if (st != ST_QOS_BOTH) result.qos_level = qos;
      end
      if (st == ST_OK) begin
        result.topic_length   = tlen_nxt;
        result.packet_ident   = (qos != 2'd0) ? ident_nxt : 16'd0;
        result.payload_length = pcount_nxt;
      end
    end
  end

  // parser state; a last byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (step && beat_in.last_byte)) begin
      phase_r  <= PH_HEADER;
      flags_r  <= '0;
      accum_r  <= '0;
      seen_r   <= '0;
      after_r  <= '0;
      tlen_r   <= '0;
      tleft_r  <= '0;
      ident_r  <= '0;
      pcount_r <= '0;
      err_r    <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      flags_r  <= flags_nxt;
      accum_r  <= accum_nxt;
      seen_r   <= seen_nxt;
      after_r  <= after_nxt;
      tlen_r   <= tlen_nxt;
      tleft_r  <= tleft_nxt;
      ident_r  <= ident_nxt;
      pcount_r <= pcount_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

FILE: src/mqtt_publish_parser_unit.sv
// MQTT PUBLISH parser, one message byte per beat.
// Input channel: in_valid / in_stall with in_data (byte plus last-byte mark).
// Output channel: out_valid / out_stall with out_data; every input beat
// yields exactly one output beat carrying the byte, its section code and,
// on the last byte, the decoded flags, lengths, packet id and status.
// Path: an accepted beat passes the input register, then parse logic into
// the output register, which presents it on the output.
// Throughput: one byte per cycle sustained while out_stall stays low; the parser state
// update is a single pass of small counters and compares between the two registers.
// Reset (rst_n low, synchronous) empties both registers and puts the parser
// back to expect a fixed header. The parser also returns there after each
// last byte, so messages follow one another with no gap.
// When the receiver stalls, the output beat holds; the input register still
// moves into an empty output slot, and in_stall rises only once both the
// input register and the output register are full.
module mqtt_publish_parser_unit
  import mpp_pkg::*;
#(
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mpp_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mpp_out_t out_data
);

  logic     in_valid_r;
  mpp_in_t  in_data_r;
  logic     out_valid_r;
  mpp_out_t out_data_r;
  logic     out_hold;
  logic     advance;
  mpp_out_t result;

  assign out_hold  = out_valid_r && out_stall;
  assign advance   = in_valid_r && !out_hold;
  assign in_stall  = in_valid_r && out_hold;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mpp_parse_core #(
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .beat_in(in_data_r),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_data_r <= in_data;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_data_r <= result;
  end

  // checks
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !in_valid_r)
    else $error("pipeline not empty after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && in_valid_r))
    else $error("input stalled without a held output");

  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.done_res) |->
      (out_data_r.status == ST_OK && out_data_r.payload_length == 28'd0 &&
       out_data_r.topic_length == 16'd0 && out_data_r.packet_ident == 16'd0))
    else $error("summary fields set on a non-last byte");

  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_OK) |->
      (out_data_r.payload_length == 28'd0 && out_data_r.packet_ident == 16'd0))
    else $error("lengths reported with an error status");

  a_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("parsed beat lost before output register");

endmodule
